@@ rtl/core/bsfr_pkg.sv @@
// Package for the byte stuffed frame receiver.
// Holds the result and configuration types, result codes and register indexes.
// No dependencies.
`default_nettype none

package bsfr_pkg;

   // Result kinds.
   localparam logic [1:0] KIND_DATA = 2'd0;
   localparam logic [1:0] KIND_GOOD = 2'd1;
   localparam logic [1:0] KIND_ERR  = 2'd2;

   // Error codes.
   localparam logic [2:0] ERR_NONE   = 3'd0;
   localparam logic [2:0] ERR_SYNC2  = 3'd1;
   localparam logic [2:0] ERR_ESCAPE = 3'd2;
   localparam logic [2:0] ERR_CHECK  = 3'd3;
   localparam logic [2:0] ERR_LONG   = 3'd4;

   // Configuration register indexes.
   localparam int unsigned CSR_INDEX_WIDTH = 2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SYNC_FIRST  = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SYNC_SECOND = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAX_LENGTH  = 2'd2;

   // Configuration reset values.
   localparam logic [7:0]  SYNC_FIRST_RESET  = 8'hAA;
   localparam logic [7:0]  SYNC_SECOND_RESET = 8'h55;
   localparam logic [15:0] MAX_LENGTH_RESET  = 16'd1024;

   typedef struct packed {
      logic [7:0]  sync_first;
      logic [7:0]  sync_second;
      logic [15:0] max_length;
   } bsfr_cfg_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  payload_byte;
      logic [15:0] byte_index;
      logic [15:0] frame_length;
      logic [2:0]  error_code;
   } bsfr_result_type;

endpackage

`default_nettype wire

@@ rtl/core/bsfr_parser.sv @@
// Frame parser: per-byte state machine that unstuffs, checks and reports.
// Depends on bsfr_pkg.
`default_nettype none

module bsfr_parser
   import bsfr_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            accept,
   input  wire logic [7:0]      rx_byte,
   input  wire bsfr_cfg_type    cfg,
   output logic                 res_valid,
   output bsfr_result_type      res
);

   typedef enum logic [2:0] {
      PH_HUNT    = 3'd0,
      PH_SYNC2   = 3'd1,
      PH_LEN_LO  = 3'd2,
      PH_LEN_HI  = 3'd3,
      PH_PAYLOAD = 3'd4,
      PH_CHECK   = 3'd5
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic        escape_ff, escape_in;
   logic [15:0] length_ff, length_in;
   logic [15:0] count_ff, count_in;
   logic [7:0]  xor_ff, xor_in;

   logic [15:0] new_length;
   logic [15:0] count_next;
   logic        data_ok;

   assign new_length = {rx_byte, length_ff[7:0]};
   assign count_next = count_ff + 16'd1;

   // Next state and result for the beat at the input.
   always_comb begin
      phase_in  = phase_ff;
      escape_in = escape_ff;
      length_in = length_ff;
      count_in  = count_ff;
      xor_in    = xor_ff;
      res_valid = 1'b0;
      res       = '0;
      data_ok   = 1'b0;
      case (phase_ff)
         PH_SYNC2: begin
            escape_in = 1'b0;
            if (rx_byte != cfg.sync_second) begin
               phase_in       = PH_HUNT;
               res_valid      = 1'b1;
               res.kind       = KIND_ERR;
               res.error_code = ERR_SYNC2;
            end else begin
               phase_in = PH_LEN_LO;
               xor_in   = 8'd0;
            end
         end
         PH_LEN_LO, PH_LEN_HI, PH_PAYLOAD, PH_CHECK: begin
            // A doubled first-sync byte stands for one data byte.
            if (escape_ff) begin
               escape_in = 1'b0;
               if (rx_byte != cfg.sync_first) begin
                  phase_in       = PH_HUNT;
                  res_valid      = 1'b1;
                  res.kind       = KIND_ERR;
                  res.error_code = ERR_ESCAPE;
               end else begin
                  data_ok = 1'b1;
               end
            end else if (rx_byte == cfg.sync_first) begin
               escape_in = 1'b1;
            end else begin
               data_ok = 1'b1;
            end
            if (data_ok) begin
               xor_in = xor_ff ^ rx_byte;
               case (phase_ff)
                  PH_LEN_LO: begin
                     length_in = {8'd0, rx_byte};
                     phase_in  = PH_LEN_HI;
                  end
                  PH_LEN_HI: begin
                     length_in = new_length;
                     if (new_length > cfg.max_length) begin
                        phase_in       = PH_HUNT;
                        escape_in      = 1'b0;
                        res_valid      = 1'b1;
                        res.kind       = KIND_ERR;
                        res.error_code = ERR_LONG;
                     end else begin
                        count_in = 16'd0;
                        phase_in = (new_length == 16'd0) ? PH_CHECK : PH_PAYLOAD;
                     end
                  end
                  PH_PAYLOAD: begin
                     count_in         = count_next;
                     res_valid        = 1'b1;
                     res.kind         = KIND_DATA;
                     res.payload_byte = rx_byte;
                     res.byte_index   = count_ff;
                     if (count_next >= length_ff) begin
                        phase_in = PH_CHECK;
                     end
                  end
                  default: begin
                     // Checksum byte closes the frame.
                     phase_in  = PH_HUNT;
                     res_valid = 1'b1;
                     if (rx_byte != xor_ff) begin
                        escape_in      = 1'b0;
                        res.kind       = KIND_ERR;
                        res.error_code = ERR_CHECK;
                     end else begin
                        res.kind = KIND_GOOD;
                     end
                  end
               endcase
            end
         end
         default: begin
            // Hunting, and any unused phase code.
            if (rx_byte == cfg.sync_first) begin
               phase_in  = PH_SYNC2;
               length_in = 16'd0;
               count_in  = 16'd0;
               xor_in    = 8'd0;
               escape_in = 1'b0;
            end else begin
               phase_in = PH_HUNT;
            end
         end
      endcase
      res.frame_length = length_in;
   end

   // Frame state, updated on each accepted beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HUNT;
         escape_ff <= 1'b0;
         length_ff <= 16'd0;
         count_ff  <= 16'd0;
         xor_ff    <= 8'd0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         escape_ff <= escape_in;
         length_ff <= length_in;
         count_ff  <= count_in;
         xor_ff    <= xor_in;
      end
   end

`ifndef NO_ASSERTIONS
   // An escape can only be pending inside the stuffed part of a frame.
   assert property (@(posedge clock) disable iff (reset)
      escape_ff |-> (phase_ff == PH_LEN_LO || phase_ff == PH_LEN_HI ||
                     phase_ff == PH_PAYLOAD || phase_ff == PH_CHECK))
      else $error("escape pending outside a frame");

   // While payload bytes remain, the index stays below the frame length.
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PAYLOAD) |-> (count_ff < length_ff))
      else $error("payload index reached frame length");

   // Every frame end sends the parser back to hunting.
   assert property (@(posedge clock) disable iff (reset)
      (accept && res_valid && res.kind != KIND_DATA) |=> (phase_ff == PH_HUNT))
      else $error("parser did not return to hunting after frame end");
`endif

endmodule

`default_nettype wire

@@ rtl/core/bsfr_out_fifo.sv @@
// Two-entry result buffer between the parser and the result channel.
// Depends on bsfr_pkg.
`default_nettype none

module bsfr_out_fifo
   import bsfr_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            wr_en,
   input  wire bsfr_result_type wr_data,
   output logic                 full,
   output logic                 rd_valid,
   input  wire logic            rd_stall,
   output bsfr_result_type      rd_data
);

   bsfr_result_type entries_ff [2];
   logic            wr_ptr_ff;
   logic            rd_ptr_ff;
   logic [1:0]      count_ff, count_in;
   logic            rd_en;

   assign full     = (count_ff == 2'd2);
   assign rd_valid = (count_ff != 2'd0);
   assign rd_en    = rd_valid && !rd_stall;
   assign rd_data  = entries_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (wr_en && !rd_en) begin
         count_in = count_ff + 2'd1;
      end else if (!wr_en && rd_en) begin
         count_in = count_ff - 2'd1;
      end
   end

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         count_ff <= count_in;
         if (wr_en) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (rd_en) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
   end

   // Result storage.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entries_ff[wr_ptr_ff] <= wr_data;
      end
   end

`ifndef NO_ASSERTIONS
   // The parser never writes into a full buffer.
   assert property (@(posedge clock) disable iff (reset)
      full |-> !wr_en)
      else $error("write into full result buffer");

   // The fill count never exceeds the two entries.
   assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("result buffer count out of range");

   // Pointers differ exactly when one entry is held.
   assert property (@(posedge clock) disable iff (reset)
      (wr_ptr_ff != rd_ptr_ff) == (count_ff == 2'd1))
      else $error("result buffer pointers disagree with count");
`endif

endmodule

`default_nettype wire

@@ rtl/core/byte_stuffed_frame_receiver.sv @@
// Byte stuffed frame receiver, top level.
// Instantiates bsfr_parser and bsfr_out_fifo; holds the configuration registers.
// Depends on bsfr_pkg.
//
// Takes one received byte per beat and can accept one in every cycle while
// the two-entry result buffer is not full. A result is written into that
// buffer when its byte is accepted; the buffer decouples the channels and
// feeds the rsp_ channel. The frame state is updated on each accepted byte.
// req_stall rises only when both entries are held because the result side is
// stalled. Configuration writes take effect from the next accepted byte on.
`default_nettype none

module byte_stuffed_frame_receiver
   import bsfr_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic [7:0]                 req_rx_byte,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic [1:0]                      rsp_kind,
   output logic [7:0]                      rsp_payload_byte,
   output logic [15:0]                     rsp_byte_index,
   output logic [15:0]                     rsp_frame_length,
   output logic [2:0]                      rsp_error_code,
   input  wire logic                       csr_write,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [15:0]                csr_data
);

   bsfr_cfg_type    cfg_ff;
   bsfr_result_type res;
   bsfr_result_type out_data;
   logic            res_valid;
   logic            accept;
   logic            fifo_full;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_first  <= SYNC_FIRST_RESET;
         cfg_ff.sync_second <= SYNC_SECOND_RESET;
         cfg_ff.max_length  <= MAX_LENGTH_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_SYNC_FIRST:  cfg_ff.sync_first  <= csr_data[7:0];
            CSR_SYNC_SECOND: cfg_ff.sync_second <= csr_data[7:0];
            CSR_MAX_LENGTH:  cfg_ff.max_length  <= csr_data;
            default: ;
         endcase
      end
   end

   assign req_stall = fifo_full;
   assign accept    = req_valid && !fifo_full;

   bsfr_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .rx_byte   (req_rx_byte),
      .cfg       (cfg_ff),
      .res_valid (res_valid),
      .res       (res)
   );

   bsfr_out_fifo u_out_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (accept && res_valid),
      .wr_data  (res),
      .full     (fifo_full),
      .rd_valid (rsp_valid),
      .rd_stall (rsp_stall),
      .rd_data  (out_data)
   );

   assign rsp_kind         = out_data.kind;
   assign rsp_payload_byte = out_data.payload_byte;
   assign rsp_byte_index   = out_data.byte_index;
   assign rsp_frame_length = out_data.frame_length;
   assign rsp_error_code   = out_data.error_code;

endmodule

`default_nettype wire

@@ bench/byte_stuffed_frame_receiver_tb.sv @@
// Self-checking testbench for byte_stuffed_frame_receiver: directed frames, then random traffic.
// Predicts every result with its own deframer and checks the rsp_ channel beat by beat.
// Depends on bsfr_pkg and byte_stuffed_frame_receiver.
`timescale 1ns / 100ps

module byte_stuffed_frame_receiver_tb
   import bsfr_pkg::*;
();

   // Deframer phases as the prediction tracks them.
   typedef enum logic [2:0] {
      HUNT_SYNC,
      WAIT_SECOND,
      LENGTH_LOW,
      LENGTH_HIGH,
      PAYLOAD_DATA,
      CHECK_BYTE
   } frame_phase_type;

   // Ways a generated frame can be damaged on purpose.
   typedef enum int {
      FRAME_CLEAN,
      FRAME_BAD_CHECKSUM,
      FRAME_BAD_SECOND,
      FRAME_BAD_ESCAPE,
      FRAME_OVERSIZE
   } frame_fault_type;

   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned PHASE_BEATS   = 100;
   localparam int unsigned MAX_REPORTS   = 50;

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   logic [7:0]                 req_rx_byte;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic [1:0]                 rsp_kind;
   logic [7:0]                 rsp_payload_byte;
   logic [15:0]                rsp_byte_index;
   logic [15:0]                rsp_frame_length;
   logic [2:0]                 rsp_error_code;
   logic                       csr_write;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [15:0]                csr_data;

   // Predicted configuration and frame state.
   bsfr_cfg_type    link_cfg;
   frame_phase_type frame_phase;
   logic            escape_seen;
   logic [15:0]     frame_len;
   logic [15:0]     payload_count;
   logic [7:0]      frame_xor;
   bsfr_result_type results_due[$];

   bit              idling_on = 1'b1;
   int unsigned     beats_sent = 0;
   int unsigned     mismatch_count = 0;

   byte_stuffed_frame_receiver DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_byte_index   (rsp_byte_index),
      .rsp_frame_length (rsp_frame_length),
      .rsp_error_code   (rsp_error_code),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always #5 clock = ~clock;

   // Gap length for either side: mostly none or short, now and then long.
   function automatic int unsigned pick_gap();
      int unsigned r;
      if (!idling_on) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic void reset_tracker();
      link_cfg.sync_first  = SYNC_FIRST_RESET;
      link_cfg.sync_second = SYNC_SECOND_RESET;
      link_cfg.max_length  = MAX_LENGTH_RESET;
      frame_phase   = HUNT_SYNC;
      escape_seen   = 1'b0;
      frame_len     = '0;
      payload_count = '0;
      frame_xor     = '0;
   endfunction

   // Advances the predicted deframer by one received byte and queues any result.
   function automatic void deframe_byte(input logic [7:0] b);
      bsfr_result_type res;
      logic            emit;
      res  = '0;
      emit = 1'b0;
      if (frame_phase == WAIT_SECOND) begin
         if (b != link_cfg.sync_second) begin
            emit           = 1'b1;
            res.kind       = KIND_ERR;
            res.error_code = ERR_SYNC2;
         end else begin
            frame_phase = LENGTH_LOW;
            frame_xor   = '0;
            escape_seen = 1'b0;
         end
      end else if (frame_phase == HUNT_SYNC) begin
         if (b == link_cfg.sync_first) begin
            frame_phase   = WAIT_SECOND;
            frame_len     = '0;
            payload_count = '0;
            frame_xor     = '0;
            escape_seen   = 1'b0;
         end
      end else if (escape_seen && b != link_cfg.sync_first) begin
         // A lone escape byte inside the frame.
         emit           = 1'b1;
         res.kind       = KIND_ERR;
         res.error_code = ERR_ESCAPE;
      end else if (!escape_seen && b == link_cfg.sync_first) begin
         escape_seen = 1'b1;
      end else begin
         escape_seen = 1'b0;
         case (frame_phase)
            LENGTH_LOW: begin
               frame_len   = {8'h00, b};
               frame_xor   = frame_xor ^ b;
               frame_phase = LENGTH_HIGH;
            end
            LENGTH_HIGH: begin
               frame_len[15:8] = b;
               frame_xor       = frame_xor ^ b;
               if (frame_len > link_cfg.max_length) begin
                  emit           = 1'b1;
                  res.kind       = KIND_ERR;
                  res.error_code = ERR_LONG;
               end else begin
                  payload_count = '0;
                  frame_phase   = (frame_len == 16'd0) ? CHECK_BYTE : PAYLOAD_DATA;
               end
            end
            PAYLOAD_DATA: begin
               emit             = 1'b1;
               res.kind         = KIND_DATA;
               res.payload_byte = b;
               res.byte_index   = payload_count;
               frame_xor        = frame_xor ^ b;
               payload_count    = payload_count + 16'd1;
               if (payload_count >= frame_len) frame_phase = CHECK_BYTE;
            end
            default: begin
               emit        = 1'b1;
               frame_phase = HUNT_SYNC;
               if (b != frame_xor) begin
                  res.kind       = KIND_ERR;
                  res.error_code = ERR_CHECK;
               end else begin
                  res.kind = KIND_GOOD;
               end
            end
         endcase
      end
      if (emit) begin
         res.frame_length = frame_len;
         if (res.kind == KIND_ERR) begin
            frame_phase = HUNT_SYNC;
            escape_seen = 1'b0;
         end
         results_due.push_back(res);
      end
   endfunction

   task automatic report_mismatch(input string what);
      if (mismatch_count < MAX_REPORTS) $display("%0t mismatch: %s", $time, what);
      mismatch_count++;
   endtask

   // Sends one beat after a random gap and holds it until the block takes it.
   task automatic drive_byte(input logic [7:0] b);
      int unsigned gap;
      gap = pick_gap();
      if (gap != 0) begin
         @(negedge clock);
         req_valid   <= 1'b0;
         req_rx_byte <= 8'($urandom);
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (req_stall);
      deframe_byte(b);
      beats_sent++;
   endtask

   // Inside a frame the escape byte goes out twice.
   task automatic send_stuffed(input logic [7:0] b);
      drive_byte(b);
      if (b == link_cfg.sync_first) drive_byte(b);
   endtask

   // Builds a frame on the fly; a broken escape replaces logical byte break_at.
   task automatic send_frame(input logic [15:0] len, input frame_fault_type fault,
                             input int unsigned break_at);
      logic [7:0]  sym;
      logic [7:0]  junk;
      logic [7:0]  sum;
      int unsigned last;
      sum = '0;
      drive_byte(link_cfg.sync_first);
      if (fault == FRAME_BAD_SECOND) begin
         junk = 8'($urandom);
         if (junk == link_cfg.sync_second) junk = junk ^ 8'h01;
         drive_byte(junk);
         return;
      end
      drive_byte(link_cfg.sync_second);
      last = (fault == FRAME_OVERSIZE) ? 1 : int'(len) + 2;
      for (int unsigned i = 0; i <= last; i++) begin
         if (i == 0) sym = len[7:0];
         else if (i == 1) sym = len[15:8];
         else if (i < last) begin
            sym = ($urandom_range(0, 3) == 0) ? link_cfg.sync_first : 8'($urandom);
         end else begin
            sym = sum;
            if (fault == FRAME_BAD_CHECKSUM) sym = sym ^ 8'($urandom_range(1, 255));
         end
         if (fault == FRAME_BAD_ESCAPE && i == break_at) begin
            junk = 8'($urandom);
            if (junk == link_cfg.sync_first) junk = junk ^ 8'h80;
            drive_byte(link_cfg.sync_first);
            drive_byte(junk);
            return;
         end
         sum = sum ^ sym;
         send_stuffed(sym);
      end
   endtask

   // Drops valid and waits until every predicted result is back and the block is quiet.
   task automatic wait_for_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (results_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes all three registers while the block is idle.
   task automatic apply_config(input bsfr_cfg_type cfg);
      wait_for_results();
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= CSR_SYNC_FIRST;
      csr_data  <= {8'($urandom), cfg.sync_first};
      @(negedge clock);
      csr_index <= CSR_SYNC_SECOND;
      csr_data  <= {8'($urandom), cfg.sync_second};
      @(negedge clock);
      csr_index <= CSR_MAX_LENGTH;
      csr_data  <= cfg.max_length;
      @(negedge clock);
      csr_write <= 1'b0;
      link_cfg = cfg;
   endtask

   // A stray byte in hunting, then a first sync followed by the wrong second byte.
   task automatic test_bad_second_sync();
      drive_byte(8'h00);
      drive_byte(8'hAA);
      drive_byte(8'h00);
   endtask

   // Zero length goes straight to the checksum, which is wrong here.
   task automatic test_empty_frame_bad_checksum();
      drive_byte(8'hAA);
      drive_byte(8'h55);
      drive_byte(8'h00);
      drive_byte(8'h00);
      drive_byte(8'hFF);
   endtask

   // A doubled escape byte in the payload folds back into one data byte.
   task automatic test_stuffed_payload();
      drive_byte(8'hAA);
      drive_byte(8'h55);
      drive_byte(8'h02);
      drive_byte(8'h00);
      drive_byte(8'hAA);
      drive_byte(8'hAA);
      drive_byte(8'hFF);
      drive_byte(8'h57);
   endtask

   // A lone escape byte in the length field.
   task automatic test_bad_escape();
      drive_byte(8'hAA);
      drive_byte(8'h55);
      drive_byte(8'hAA);
      drive_byte(8'h01);
   endtask

   // A length of 0x0501 exceeds the default limit.
   task automatic test_oversize_length();
      drive_byte(8'hAA);
      drive_byte(8'h55);
      drive_byte(8'h01);
      drive_byte(8'h05);
   endtask

   // Frames right at the length limit and one above it, then a broken escape in the checksum byte.
   task automatic test_length_limit();
      bsfr_cfg_type cfg;
      cfg = '{sync_first: 8'hAA, sync_second: 8'h55, max_length: 16'd100};
      apply_config(cfg);
      send_frame(16'd100, FRAME_CLEAN, 0);
      send_frame(16'd101, FRAME_OVERSIZE, 0);
      send_frame(16'd100, FRAME_BAD_ESCAPE, 102);
   endtask

   // Extreme register values, including a zero limit and the full 16-bit length.
   task automatic test_config_extremes();
      bsfr_cfg_type cfg;
      cfg = '{sync_first: 8'h00, sync_second: 8'hFF, max_length: 16'h0000};
      apply_config(cfg);
      send_frame(16'd0, FRAME_CLEAN, 0);
      send_frame(16'd0, FRAME_BAD_CHECKSUM, 0);
      send_frame(16'd1, FRAME_OVERSIZE, 0);
      send_frame(16'hFFFF, FRAME_OVERSIZE, 0);
      send_frame(16'd0, FRAME_BAD_ESCAPE, 2);
      cfg = '{sync_first: 8'hFF, sync_second: 8'h00, max_length: 16'hFFFF};
      apply_config(cfg);
      send_frame(16'hFFFF, FRAME_BAD_ESCAPE, 5);
      send_frame(16'd3, FRAME_CLEAN, 0);
      send_frame(16'd0, FRAME_BAD_SECOND, 0);
   endtask

   // One random frame, mostly well formed, sometimes broken or plain noise.
   task automatic send_random_traffic();
      int unsigned     pick;
      int unsigned     r;
      int unsigned     len;
      frame_fault_type fault;
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
         repeat ($urandom_range(1, 5)) drive_byte(8'($urandom));
         return;
      end
      r = $urandom_range(0, 99);
      if (r < 60) len = $urandom_range(0, 6);
      else if (r < 92) len = $urandom_range(7, 24);
      else len = $urandom_range(25, 80);
      if (len > link_cfg.max_length) len = link_cfg.max_length;
      if (pick < 73) fault = FRAME_CLEAN;
      else if (pick < 81) fault = FRAME_BAD_CHECKSUM;
      else if (pick < 88) fault = FRAME_BAD_SECOND;
      else if (pick < 96) fault = FRAME_BAD_ESCAPE;
      else fault = FRAME_OVERSIZE;
      if (fault == FRAME_OVERSIZE) begin
         if (link_cfg.max_length == 16'hFFFF) fault = FRAME_CLEAN;
         else if ($urandom_range(0, 1) == 0) len = $urandom_range(link_cfg.max_length + 1, 65535);
         else len = link_cfg.max_length + 1;
      end
      send_frame(16'(len), fault, $urandom_range(0, len + 2));
   endtask

   // Several register settings, each with a stretch of random frames.
   task automatic test_random_traffic();
      bsfr_cfg_type cfg;
      int unsigned  start;
      for (int p = 0; p < 8; p++) begin
         if (p == 0) begin
            cfg = '{sync_first: SYNC_FIRST_RESET, sync_second: SYNC_SECOND_RESET,
                    max_length: MAX_LENGTH_RESET};
         end else begin
            cfg.sync_first  = 8'($urandom);
            cfg.sync_second = (p == 3) ? cfg.sync_first : 8'($urandom);
            case ($urandom_range(0, 2))
               0: cfg.max_length = 16'($urandom_range(0, 16));
               1: cfg.max_length = 16'($urandom);
               default: cfg.max_length = 16'hFFFF;
            endcase
         end
         apply_config(cfg);
         idling_on = (p % 3 != 2);
         start = beats_sent;
         while (beats_sent - start < PHASE_BEATS) send_random_traffic();
      end
      idling_on = 1'b1;
   endtask

   // Result side stall: random stalled stretches between short free runs.
   initial begin : rsp_stall_driver
      int unsigned run;
      forever begin
         run = pick_gap();
         repeat (run) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
         end
         run = $urandom_range(1, 8);
         repeat (run) begin
            @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Compares every accepted result beat with the oldest prediction.
   always @(posedge clock) begin : result_checker
      bsfr_result_type due;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (results_due.size() == 0) begin
            report_mismatch($sformatf("unexpected result, kind %0d", rsp_kind));
         end else begin
            due = results_due.pop_front();
            if (rsp_kind !== due.kind)
               report_mismatch($sformatf("kind got %0d want %0d", rsp_kind, due.kind));
            if (rsp_payload_byte !== due.payload_byte)
               report_mismatch($sformatf("payload_byte got %0h want %0h",
                                         rsp_payload_byte, due.payload_byte));
            if (rsp_byte_index !== due.byte_index)
               report_mismatch($sformatf("byte_index got %0d want %0d",
                                         rsp_byte_index, due.byte_index));
            if (rsp_frame_length !== due.frame_length)
               report_mismatch($sformatf("frame_length got %0d want %0d",
                                         rsp_frame_length, due.frame_length));
            if (rsp_error_code !== due.error_code)
               report_mismatch($sformatf("error_code got %0d want %0d",
                                         rsp_error_code, due.error_code));
         end
      end
   end

   initial begin : test_sequence
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_rx_byte = 8'h00;
      csr_write   = 1'b0;
      csr_index   = CSR_SYNC_FIRST;
      csr_data    = 16'h0000;
      reset_tracker();
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      test_bad_second_sync();
      test_empty_frame_bad_checksum();
      test_stuffed_payload();
      test_bad_escape();
      test_oversize_length();
      test_length_limit();
      test_config_extremes();
      test_random_traffic();

      wait_for_results();
      if (mismatch_count == 0) begin
         $display("[byte_stuffed_frame_receiver] OK");
      end else begin
         $display("[byte_stuffed_frame_receiver] ERROR");
      end
      $finish;
   end

   // Hard limit on the run.
   initial begin : run_limit
      #10ms;
      $display("[byte_stuffed_frame_receiver] ERROR");
      $finish;
   end

endmodule
